// ===== rtl/core/ocrp_pkg.sv =====
// Shared types and constants for the oxygen cell reply parser.
`timescale 1ns / 1ps
package ocrp_pkg;
   localparam int LINE_BYTES    = 86;
   localparam int DETAIL_FIELDS = 8;
   localparam int SIMPLE_FIELDS = 3;
   localparam int CMD_LEN       = 5;
   localparam int LEN_W         = $clog2(LINE_BYTES);
   localparam int FIDX_W        = $clog2(DETAIL_FIELDS);
   localparam logic [15:0] FAIL_BITS = 16'h003E;
   localparam logic [15:0] WARN_BITS = 16'h01C1;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [1:0] {
      PH_SKIP = 2'd0,
      PH_LINE = 2'd1,
      PH_DONE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_FEED  = 2'd1,
      OP_CLOSE = 2'd2,
      OP_END   = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] ch;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DEGRADED = 2'd1,
      ST_FAIL     = 2'd2
   } status_type;

   function automatic logic [7:0] cmd_detail(input logic [2:0] p);
      logic [7:0] r;
      unique case (p)
         3'd0: r = 8'h23;
         3'd1: r = 8'h44;
         3'd2: r = 8'h52;
         3'd3: r = 8'h41;
         3'd4: r = 8'h57;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] cmd_simple(input logic [2:0] p);
      logic [7:0] r;
      unique case (p)
         3'd0: r = 8'h23;
         3'd1: r = 8'h44;
         3'd2: r = 8'h4F;
         3'd3: r = 8'h58;
         3'd4: r = 8'h59;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] status_of(input logic [31:0] w);
      logic [1:0] r;
      if ((w[15:0] & FAIL_BITS) != 16'd0) r = ST_FAIL;
      else if ((w[15:0] & WARN_BITS) != 16'd0) r = ST_DEGRADED;
      else if (w[15:0] != 16'd0) r = ST_FAIL;
      else r = ST_OK;
      return r;
   endfunction
endpackage

// ===== rtl/core/ocrp_front.sv =====
// Front end: line framing, turns raw beats into feed, close and end commands.
`timescale 1ns / 1ps
module ocrp_front
   import ocrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_reception_end,
   output logic        cmd_valid,
   output cmd_type     cmd,
   input  logic        cmd_full
);
   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             take;
   logic             is_term;
   logic             is_junk;

   assign req_stall = cmd_full;
   assign take      = req_valid && !cmd_full;
   assign is_term   = req_rx_byte == CH_NUL || req_rx_byte == CH_CR || req_rx_byte == CH_LF;
   assign is_junk   = req_rx_byte == CH_NUL || req_rx_byte == CH_CR;

   always_comb begin
      phase_in  = phase_ff;
      len_in    = len_ff;
      cmd_valid = 1'b0;
      cmd.op    = OP_NONE;
      cmd.ch    = req_rx_byte;
      if (take) begin
         if (req_reception_end) begin
            cmd_valid = 1'b1;
            cmd.op    = OP_END;
            phase_in  = PH_SKIP;
            len_in    = '0;
         end else begin
            unique case (phase_ff)
               PH_SKIP: begin
                  if (is_junk && len_ff < LEN_W'(LINE_BYTES - 1)) begin
                     len_in = len_ff + 1'b1;
                  end else if (is_term) begin
                     cmd_valid = 1'b1;
                     cmd.op    = OP_CLOSE;
                     phase_in  = PH_DONE;
                  end else begin
                     cmd_valid = 1'b1;
                     cmd.op    = OP_FEED;
                     len_in    = LEN_W'(1);
                     phase_in  = PH_LINE;
                  end
               end
               PH_LINE: begin
                  cmd_valid = 1'b1;
                  if (is_term) begin
                     cmd.op   = OP_CLOSE;
                     phase_in = PH_DONE;
                  end else begin
                     cmd.op = OP_FEED;
                     len_in = len_ff + 1'b1;
                  end
               end
               default: begin
               end
            endcase
            if (phase_in == PH_LINE && len_in >= LEN_W'(LINE_BYTES - 1)) begin
               phase_in = PH_DONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         len_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
      end
   end
endmodule

// ===== rtl/core/ocrp_queue.sv =====
// Two-entry command queue between front and back ends.
`timescale 1ns / 1ps
module ocrp_queue
   import ocrp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   input  cmd_type wr_cmd,
   output logic    full,
   output logic    rd_valid,
   output cmd_type rd_cmd,
   input  logic    rd_take
);
   cmd_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       wr, rd;

   assign full     = cnt_ff == 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_cmd   = mem_ff[rp_ff];
   assign wr       = wr_valid && !full;
   assign rd       = rd_take && rd_valid;

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr} - {1'b0, rd};
      end
   end
endmodule

// ===== rtl/core/ocrp_back.sv =====
// Back end: tokenizer, command match, decimal accumulation and reply output.
`timescale 1ns / 1ps
module ocrp_back
   import ocrp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  cmd_type            cmd,
   output logic               cmd_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_parse_ok,
   output logic               rsp_reply_kind,
   output logic signed [31:0] rsp_raw_ppo2,
   output logic signed [31:0] rsp_temperature_dc,
   output logic signed [31:0] rsp_error_word,
   output logic signed [31:0] rsp_optical_phase,
   output logic signed [31:0] rsp_signal_intensity,
   output logic signed [31:0] rsp_ambient_level,
   output logic signed [31:0] rsp_pressure_reading,
   output logic signed [31:0] rsp_humidity_reading,
   output logic [1:0]         rsp_cell_status
);
   logic [3:0]  tok_ff, tok_in;
   logic        intok_ff, intok_in;
   logic [1:0]  match_ff, match_in;
   logic [2:0]  ccnt_ff, ccnt_in;
   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic        stop_ff, stop_in;
   logic        sat_ff, sat_in;
   logic [1:0]  stage_ff, stage_in;
   logic [31:0] fld_ff [DETAIL_FIELDS];
   logic        fld_we;
   logic [FIDX_W-1:0] fld_idx;
   logic [31:0] numval;
   logic        finish;
   logic [3:0]  tok_f;
   logic [1:0]  match_f;
   logic        is_digit;
   logic [35:0] mul;
   logic        out_free;
   logic        ov_ff;
   logic        ok_ff, kind_ff;
   logic [31:0] o_ff [DETAIL_FIELDS];
   logic [1:0]  st_ff;
   logic        do_end;
   logic        det_ok, sim_ok;

   assign out_free = !ov_ff || !rsp_stall;
   assign cmd_take = cmd_valid && (cmd.op != OP_END || out_free);
   assign do_end   = cmd_valid && cmd.op == OP_END && out_free;
   assign is_digit = cmd.ch >= CH_ZERO && cmd.ch <= CH_NINE;
   assign mul      = {4'd0, mag_ff} * 36'd10 + {32'd0, cmd.ch[3:0]};

   always_comb begin
      if (neg_ff) numval = sat_ff ? 32'h8000_0000 : 32'd0 - mag_ff;
      else numval = (sat_ff || mag_ff[31]) ? 32'h7FFF_FFFF : mag_ff;
   end

   // finish_token: token closes on space, terminator or end
   always_comb begin
      tok_in   = tok_ff;
      intok_in = intok_ff;
      match_in = match_ff;
      ccnt_in  = ccnt_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      stop_in  = stop_ff;
      sat_in   = sat_ff;
      stage_in = stage_ff;
      fld_we   = 1'b0;
      fld_idx  = FIDX_W'(tok_ff - 4'd1);
      finish   = 1'b0;
      if (cmd_take && (cmd.op == OP_CLOSE || cmd.op == OP_END ||
                       (cmd.op == OP_FEED && cmd.ch == CH_SPACE))) begin
         finish = intok_ff;
      end
      tok_f   = tok_ff;
      match_f = match_ff;
      if (finish) begin
         intok_in = 1'b0;
         if (tok_ff == 4'd0) begin
            if (ccnt_ff != 3'(CMD_LEN)) match_f = 2'b00;
         end else if (tok_ff <= 4'(DETAIL_FIELDS)) begin
            fld_we = 1'b1;
         end
         if (tok_ff < 4'd15) tok_f = tok_ff + 4'd1;
      end
      tok_in   = tok_f;
      match_in = match_f;
      if (cmd_take && cmd.op == OP_FEED && cmd.ch != CH_SPACE) begin
         if (!intok_ff) begin
            intok_in = 1'b1;
            mag_in   = '0;
            neg_in   = 1'b0;
            stop_in  = 1'b0;
            sat_in   = 1'b0;
            stage_in = 2'd0;
         end else begin
            mag_in   = mag_ff;
            neg_in   = neg_ff;
            stop_in  = stop_ff;
            sat_in   = sat_ff;
            stage_in = stage_ff;
         end
         if (tok_ff == 4'd0) begin
            if (ccnt_ff < 3'(CMD_LEN)) begin
               if (cmd.ch != cmd_detail(ccnt_ff)) match_in[0] = 1'b0;
               if (cmd.ch != cmd_simple(ccnt_ff)) match_in[1] = 1'b0;
            end else begin
               match_in = 2'b00;
            end
            if (ccnt_ff < 3'd7) ccnt_in = ccnt_ff + 3'd1;
         end else if (tok_ff <= 4'(DETAIL_FIELDS) && !(intok_ff && stop_ff)) begin
            if (is_digit) begin
               if (!intok_ff) begin
                  mag_in = {28'd0, cmd.ch[3:0]};
               end else if (mul > 36'h0_8000_0000) begin
                  sat_in = 1'b1;
                  mag_in = 32'h8000_0000;
               end else begin
                  mag_in = mul[31:0];
               end
               stage_in = 2'd2;
            end else if ((!intok_ff || stage_ff == 2'd0) &&
                         (cmd.ch == CH_TAB || cmd.ch == CH_VT || cmd.ch == CH_FF)) begin
               stage_in = 2'd0;
            end else if ((!intok_ff || stage_ff == 2'd0) &&
                         (cmd.ch == CH_PLUS || cmd.ch == CH_MINUS)) begin
               neg_in   = cmd.ch == CH_MINUS;
               stage_in = 2'd1;
            end else begin
               stop_in = 1'b1;
            end
         end
      end
      if (do_end) begin
         tok_in   = '0;
         intok_in = 1'b0;
         match_in = 2'b11;
         ccnt_in  = '0;
         mag_in   = '0;
         neg_in   = 1'b0;
         stop_in  = 1'b0;
         sat_in   = 1'b0;
         stage_in = 2'd0;
      end
   end

   assign det_ok = match_f[0] && tok_f >= 4'(1 + DETAIL_FIELDS);
   assign sim_ok = match_f[1] && tok_f >= 4'(1 + SIMPLE_FIELDS);

   always_ff @(posedge clock) begin
      if (fld_we) fld_ff[fld_idx] <= numval;
   end

   always_ff @(posedge clock) begin
      if (do_end) begin
         for (int i = 0; i < DETAIL_FIELDS; i++) o_ff[i] <= '0;
         ok_ff   <= 1'b0;
         kind_ff <= 1'b0;
         st_ff   <= ST_OK;
         if (det_ok) begin
            ok_ff <= 1'b1;
            for (int i = 0; i < DETAIL_FIELDS; i++) begin
               o_ff[i] <= (fld_we && fld_idx == FIDX_W'(i)) ? numval : fld_ff[i];
            end
            st_ff <= status_of((fld_we && fld_idx == FIDX_W'(2)) ? numval : fld_ff[2]);
         end else if (sim_ok) begin
            ok_ff   <= 1'b1;
            kind_ff <= 1'b1;
            o_ff[0] <= (fld_we && fld_idx == FIDX_W'(0)) ? numval : fld_ff[0];
            o_ff[1] <= (fld_we && fld_idx == FIDX_W'(1)) ? numval : fld_ff[1];
            st_ff   <= status_of((fld_we && fld_idx == FIDX_W'(2)) ? numval : fld_ff[2]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         intok_ff <= 1'b0;
         match_ff <= 2'b11;
         ccnt_ff  <= '0;
         mag_ff   <= '0;
         neg_ff   <= 1'b0;
         stop_ff  <= 1'b0;
         sat_ff   <= 1'b0;
         stage_ff <= 2'd0;
         ov_ff    <= 1'b0;
      end else begin
         tok_ff   <= tok_in;
         intok_ff <= intok_in;
         match_ff <= match_in;
         ccnt_ff  <= ccnt_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         stop_ff  <= stop_in;
         sat_ff   <= sat_in;
         stage_ff <= stage_in;
         if (do_end) ov_ff <= 1'b1;
         else if (!rsp_stall) ov_ff <= 1'b0;
      end
   end

   assign rsp_valid            = ov_ff;
   assign rsp_parse_ok         = ok_ff;
   assign rsp_reply_kind       = kind_ff;
   assign rsp_raw_ppo2         = o_ff[0];
   assign rsp_temperature_dc   = o_ff[1];
   assign rsp_error_word       = o_ff[2];
   assign rsp_optical_phase    = o_ff[3];
   assign rsp_signal_intensity = o_ff[4];
   assign rsp_ambient_level    = o_ff[5];
   assign rsp_pressure_reading = o_ff[6];
   assign rsp_humidity_reading = o_ff[7];
   assign rsp_cell_status      = st_ff;
endmodule

// ===== rtl/core/oxygen_cell_reply_parser.sv =====
// Top level of the oxygen cell reply parser.
//   channel  dir  handshake          beat
//   req_     in   req_valid/stall    one byte or a reception end
//   rsp_     out  rsp_valid/stall    one parsed reading per reception
// One beat per cycle sustained while unstalled; the front frames the line, a
// two-entry queue decouples it from the tokenizer, which accumulates digits in one
// multiply-add per byte. With the queue empty, the end beat passes a queue entry,
// then sets the registered reading. Reset is synchronous and clears all control
// state. Stall on rsp_ holds the reading and backs up through the queue to req_.
`timescale 1ns / 1ps
module oxygen_cell_reply_parser
   import ocrp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_reception_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_parse_ok,
   output logic               rsp_reply_kind,
   output logic signed [31:0] rsp_raw_ppo2,
   output logic signed [31:0] rsp_temperature_dc,
   output logic signed [31:0] rsp_error_word,
   output logic signed [31:0] rsp_optical_phase,
   output logic signed [31:0] rsp_signal_intensity,
   output logic signed [31:0] rsp_ambient_level,
   output logic signed [31:0] rsp_pressure_reading,
   output logic signed [31:0] rsp_humidity_reading,
   output logic [1:0]         rsp_cell_status
);
   logic    f_valid, q_full, q_valid, q_take;
   cmd_type f_cmd, q_cmd;

   ocrp_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_rx_byte, .req_reception_end,
      .cmd_valid(f_valid), .cmd(f_cmd), .cmd_full(q_full)
   );

   ocrp_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_cmd(f_cmd), .full(q_full),
      .rd_valid(q_valid), .rd_cmd(q_cmd), .rd_take(q_take)
   );

   ocrp_back u_back (
      .clock, .reset, .cmd_valid(q_valid), .cmd(q_cmd), .cmd_take(q_take),
      .rsp_valid, .rsp_stall, .rsp_parse_ok, .rsp_reply_kind, .rsp_raw_ppo2,
      .rsp_temperature_dc, .rsp_error_word, .rsp_optical_phase,
      .rsp_signal_intensity, .rsp_ambient_level, .rsp_pressure_reading,
      .rsp_humidity_reading, .rsp_cell_status
   );
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the oxygen cell reply parser: directed and random replies.
`timescale 1ns / 1ps
module testbench;
   import ocrp_pkg::*;

   localparam int    LIMIT_CYCLES = 4000;
   localparam int    BEAT_TARGET  = 1400;
   localparam string DETAIL_CMD   = "#DRAW";
   localparam string SIMPLE_CMD   = "#DOXY";

   typedef struct {
      bit                 ok;
      bit                 kind;
      logic signed [31:0] f [8];
      logic [1:0]         st;
   } reading_type;

   typedef struct {
      int    lead;
      int    pad;
      string text;
      int    term;
      string tail;
      bit    typed;
      reading_type exp;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'd0;
   logic               req_reception_end = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_parse_ok;
   logic               rsp_reply_kind;
   logic signed [31:0] rsp_raw_ppo2;
   logic signed [31:0] rsp_temperature_dc;
   logic signed [31:0] rsp_error_word;
   logic signed [31:0] rsp_optical_phase;
   logic signed [31:0] rsp_signal_intensity;
   logic signed [31:0] rsp_ambient_level;
   logic signed [31:0] rsp_pressure_reading;
   logic signed [31:0] rsp_humidity_reading;
   logic [1:0]         rsp_cell_status;

   oxygen_cell_reply_parser u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_rx_byte(req_rx_byte), .req_reception_end(req_reception_end),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_parse_ok(rsp_parse_ok), .rsp_reply_kind(rsp_reply_kind),
      .rsp_raw_ppo2(rsp_raw_ppo2), .rsp_temperature_dc(rsp_temperature_dc),
      .rsp_error_word(rsp_error_word), .rsp_optical_phase(rsp_optical_phase),
      .rsp_signal_intensity(rsp_signal_intensity), .rsp_ambient_level(rsp_ambient_level),
      .rsp_pressure_reading(rsp_pressure_reading),
      .rsp_humidity_reading(rsp_humidity_reading),
      .rsp_cell_status(rsp_cell_status)
   );

   always #6 clock = ~clock;

   // parser shadow state
   phase_type   sh_phase;
   int unsigned sh_len, sh_tok, sh_ccnt, sh_stage;
   bit          sh_intok, sh_neg, sh_stop, sh_sat;
   logic [1:0]  sh_match;
   logic [31:0] sh_mag;
   logic [31:0] sh_fields [8];

   reading_type readings_due [$];
   logic [7:0]  line_q [$];
   row_type     rows [$];

   int  beats, receptions, good_readings, readings_seen, mismatches;
   int  idle_cycles;
   bit  calm;
   bit  held_off;

   function automatic logic [31:0] field_value();
      logic [31:0] v;
      if (sh_neg) v = sh_sat ? 32'h8000_0000 : 32'd0 - sh_mag;
      else if (sh_sat || sh_mag > 32'h7FFF_FFFF) v = 32'h7FFF_FFFF;
      else v = sh_mag;
      return v;
   endfunction

   function automatic status_type cell_health(input logic [31:0] w);
      status_type s;
      if ((w[15:0] & FAIL_BITS) != 16'd0) s = ST_FAIL;
      else if ((w[15:0] & WARN_BITS) != 16'd0) s = ST_DEGRADED;
      else if (w[15:0] != 16'd0) s = ST_FAIL;
      else s = ST_OK;
      return s;
   endfunction

   task automatic close_token();
      if (sh_intok) begin
         sh_intok = 1'b0;
         if (sh_tok == 0) begin
            if (sh_ccnt != CMD_LEN) sh_match = 2'b00;
         end else if (sh_tok <= DETAIL_FIELDS) begin
            sh_fields[sh_tok - 1] = field_value();
         end
         if (sh_tok < 15) sh_tok++;
      end
   endtask

   task automatic restart_line();
      sh_phase = PH_SKIP;
      sh_len   = 0;
      sh_tok   = 0;
      sh_intok = 1'b0;
      sh_match = 2'b11;
      sh_ccnt  = 0;
      sh_mag   = 32'd0;
      sh_neg   = 1'b0;
      sh_stop  = 1'b0;
      sh_sat   = 1'b0;
      sh_stage = 0;
   endtask

   task automatic take_char(input logic [7:0] c);
      logic [63:0] acc;
      if (c == CH_NUL || c == CH_CR || c == CH_LF) begin
         close_token();
         sh_phase = PH_DONE;
         return;
      end
      if (c == CH_SPACE) begin
         close_token();
      end else begin
         if (!sh_intok) begin
            sh_intok = 1'b1;
            sh_mag   = 32'd0;
            sh_neg   = 1'b0;
            sh_stop  = 1'b0;
            sh_sat   = 1'b0;
            sh_stage = 0;
         end
         if (sh_tok == 0) begin
            if (sh_ccnt < CMD_LEN) begin
               if (c != DETAIL_CMD[sh_ccnt]) sh_match[0] = 1'b0;
               if (c != SIMPLE_CMD[sh_ccnt]) sh_match[1] = 1'b0;
            end else begin
               sh_match = 2'b00;
            end
            if (sh_ccnt < 7) sh_ccnt++;
         end else if (sh_tok <= DETAIL_FIELDS && !sh_stop) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
               acc = {32'd0, sh_mag} * 64'd10 + 64'(c - CH_ZERO);
               if (acc > 64'h8000_0000) begin
                  sh_sat = 1'b1;
                  acc    = 64'h8000_0000;
               end
               sh_mag   = acc[31:0];
               sh_stage = 2;
            end else if (sh_stage == 0 && (c == CH_TAB || c == CH_VT || c == CH_FF)) begin
            end else if (sh_stage == 0 && (c == CH_PLUS || c == CH_MINUS)) begin
               sh_neg   = (c == CH_MINUS);
               sh_stage = 1;
            end else begin
               sh_stop = 1'b1;
            end
         end
      end
      sh_len++;
      if (sh_len >= LINE_BYTES - 1) begin
         close_token();
         sh_phase = PH_DONE;
      end
   endtask

   task automatic predict_beat(input logic [7:0] c, input bit e,
                               output bit has, output reading_type r);
      has = 1'b0;
      r.ok = 1'b0;
      r.kind = 1'b0;
      r.st = ST_OK;
      for (int i = 0; i < 8; i++) r.f[i] = 32'sd0;
      if (!e) begin
         if (sh_phase == PH_SKIP) begin
            if ((c == CH_NUL || c == CH_CR) && sh_len < LINE_BYTES - 1) begin
               sh_len++;
               return;
            end
            sh_phase = PH_LINE;
            sh_len   = 0;
         end
         if (sh_phase == PH_LINE) take_char(c);
         return;
      end
      has = 1'b1;
      if (sh_phase == PH_LINE) close_token();
      if (sh_tok >= 1 + DETAIL_FIELDS && sh_match[0]) begin
         r.ok = 1'b1;
         for (int i = 0; i < 8; i++) r.f[i] = sh_fields[i];
         r.st = cell_health(sh_fields[2]);
      end else if (sh_tok >= 1 + SIMPLE_FIELDS && sh_match[1]) begin
         r.ok   = 1'b1;
         r.kind = 1'b1;
         r.f[0] = sh_fields[0];
         r.f[1] = sh_fields[1];
         r.st   = cell_health(sh_fields[2]);
      end
      restart_line();
   endtask

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (calm || p < 45) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_beat(input logic [7:0] c, input bit e, input bit typed,
                            input reading_type tr);
      bit          has;
      reading_type r;
      int          n;
      req_valid         <= 1'b1;
      req_rx_byte       <= c;
      req_reception_end <= e;
      do @(posedge clock); while (req_stall);
      predict_beat(c, e, has, r);
      beats++;
      if (has) begin
         receptions++;
         readings_due.push_back(typed ? tr : r);
      end
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_line(input bit typed, input reading_type tr);
      foreach (line_q[i]) send_beat(line_q[i], 1'b0, 1'b0, tr);
      send_beat($urandom_range(0, 255), 1'b1, typed, tr);
      if ($urandom_range(0, 49) == 0) calm = ~calm;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endtask

   function automatic reading_type mk(input bit ok, input bit kind, input int a,
                                      input int b, input status_type st);
      reading_type r;
      r.ok = ok;
      r.kind = kind;
      for (int i = 0; i < 8; i++) r.f[i] = 32'sd0;
      r.f[0] = a;
      r.f[1] = b;
      r.st = st;
      return r;
   endfunction

   task automatic add_row(input int lead, input int pad, input string text,
                          input int term, input string tail, input bit typed,
                          input reading_type exp);
      row_type w;
      w.lead = lead;
      w.pad = pad;
      w.text = text;
      w.term = term;
      w.tail = tail;
      w.typed = typed;
      w.exp = exp;
      rows.push_back(w);
   endtask

   task automatic push_number(input bit is_err);
      int k;
      int nd;
      k = $urandom_range(0, 9);
      if ($urandom_range(0, 9) == 0)
         line_q.push_back(k < 3 ? CH_TAB : (k < 6 ? CH_VT : CH_FF));
      if (is_err && k < 7) begin
         case ($urandom_range(0, 3))
            0: push_text("0");
            1: push_text($sformatf("%0d", 32'd1 << $urandom_range(0, 8)));
            2: push_text($sformatf("%0d", $urandom_range(0, 511)));
            default: push_text($sformatf("%0d", $urandom_range(0, 65535)));
         endcase
      end else if (k == 8) begin
         case ($urandom_range(0, 3))
            0: push_text("2147483647");
            1: push_text("-2147483648");
            2: push_text("2147483648");
            default: push_text("-2147483649");
         endcase
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2: line_q.push_back(CH_MINUS);
            3: line_q.push_back(CH_PLUS);
            default: ;
         endcase
         if (k < 4) push_text($sformatf("%0d", $urandom_range(0, 999)));
         else if (k < 7) push_text($sformatf("%0d", $urandom()));
         else if (k == 7) begin
            nd = $urandom_range(10, 14);
            repeat (nd) line_q.push_back(CH_ZERO + $urandom_range(0, 9));
         end
      end
      if ($urandom_range(0, 9) == 0) push_text($urandom_range(0, 1) ? "x" : ".5");
   endtask

   task automatic random_reception();
      int    p, nf, lead, t;
      string cmd;
      reading_type none;
      none = mk(1'b0, 1'b0, 0, 0, ST_OK);
      line_q.delete();
      p = $urandom_range(0, 99);
      lead = ($urandom_range(0, 19) == 0) ? $urandom_range(80, 90) : $urandom_range(0, 3);
      repeat (lead) line_q.push_back($urandom_range(0, 1) ? CH_CR : CH_NUL);
      if (p < 10) begin
         repeat ($urandom_range(1, 30)) line_q.push_back($urandom_range(0, 255));
      end else begin
         if (p < 45) begin
            cmd = DETAIL_CMD;
            nf = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : $urandom_range(8, 10);
         end else begin
            cmd = SIMPLE_CMD;
            nf = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : $urandom_range(3, 5);
         end
         if ($urandom_range(0, 11) == 0) cmd[$urandom_range(0, 4)] = $urandom_range(33, 126);
         if ($urandom_range(0, 19) == 0) cmd = cmd.substr(0, $urandom_range(0, 3));
         if ($urandom_range(0, 19) == 0) cmd = {cmd, "Z"};
         if ($urandom_range(0, 9) == 0) line_q.push_back(CH_SPACE);
         push_text(cmd);
         for (int i = 0; i < nf; i++) begin
            repeat ($urandom_range(0, 5) == 0 ? 2 : 1) line_q.push_back(CH_SPACE);
            push_number(i == 2);
         end
         if ($urandom_range(0, 14) == 0)
            repeat ($urandom_range(20, 90)) line_q.push_back($urandom_range(33, 126));
      end
      t = $urandom_range(0, 3);
      if (t != 0) begin
         line_q.push_back(t == 1 ? CH_NUL : (t == 2 ? CH_CR : CH_LF));
         repeat ($urandom_range(0, 4)) line_q.push_back($urandom_range(0, 255));
      end
      send_line(1'b0, none);
   endtask

   // stimulus
   initial begin
      reading_type z;
      z = mk(1'b0, 1'b0, 0, 0, ST_OK);
      restart_line();
      for (int i = 0; i < 8; i++) sh_fields[i] = 32'd0;
      add_row(0, 0, "", -1, "", 1'b1, z);
      add_row(3, 0, "#DOXY 1 2 3", CH_CR, "", 1'b1, mk(1, 1, 1, 2, ST_FAIL));
      add_row(0, 0, "#DOXY 2147483647 -2147483648 65535", -1, "", 1'b1,
              mk(1, 1, 32'h7FFFFFFF, 32'h80000000, ST_FAIL));
      add_row(0, 0, "#DOXY 99999999999 -99999999999 1", CH_LF, "", 1'b1,
              mk(1, 1, 32'h7FFFFFFF, 32'h80000000, ST_DEGRADED));
      add_row(0, 0, "#DOXY +5 -0 0", CH_NUL, "", 1'b1, mk(1, 1, 5, 0, ST_OK));
      add_row(0, 0, "#DOXY \t-12x 3abc 64", -1, "", 1'b1, mk(1, 1, -12, 3, ST_DEGRADED));
      add_row(0, 0, "#DRAW 1 -2 256 4 5 6 7 8", -1, "", 1'b0, z);
      add_row(0, 0, "#DRAW 1 2 32 4 5 6 7 8 9 10", CH_CR, "", 1'b0, z);
      add_row(0, 0, "#DRAW 1 2 3 4 5 6 7", -1, "", 1'b1, z);
      add_row(0, 0, "#DOXY 1 2", -1, "", 1'b1, z);
      add_row(0, 0, "#DRAWX 1 2 3 4 5 6 7 8", -1, "", 1'b1, z);
      add_row(0, 0, "#DOX 1 2 3", -1, "", 1'b1, z);
      add_row(86, 0, "#DOXY 1 2 3", -1, "", 1'b1, z);
      add_row(84, 0, "#DOXY 4 5 0", -1, "", 1'b1, mk(1, 1, 4, 5, ST_OK));
      add_row(0, 80, "#DOXY 1 2 3", -1, "", 1'b1, z);
      add_row(0, 2, "#DOXY  7 8  4096 ", CH_LF, "#DRAW 9", 1'b1,
              mk(1, 1, 7, 8, ST_FAIL));
      add_row(0, 0, "#DOXY 1 2 3 -", -1, "", 1'b1, mk(1, 1, 1, 2, ST_FAIL));
      add_row(0, 0, "#DRAW -2147483649 2147483648 128 + - 9 000012 -0x5", -1, "",
              1'b0, z);
      add_row(0, 0, "#DOXY +-3 4 0", -1, "", 1'b0, z);
      add_row(0, 0, "#DRAW 0 0 0 0 0 0 0 0", -1, "", 1'b0, z);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         line_q.delete();
         for (int j = 0; j < rows[i].lead; j++) line_q.push_back(j % 2 ? CH_CR : CH_NUL);
         repeat (rows[i].pad) line_q.push_back(CH_SPACE);
         push_text(rows[i].text);
         if (rows[i].term >= 0) line_q.push_back(rows[i].term);
         push_text(rows[i].tail);
         send_line(rows[i].typed, rows[i].exp);
      end
      while (beats < BEAT_TARGET) random_reception();
      req_valid <= 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("%0d beats, %0d receptions, %0d valid readings checked",
               beats, receptions, good_readings);
      $display("receiver hold-off exercised: %0d, mismatches: %0d", held_off, mismatches);
      if (mismatches == 0 && readings_due.size() == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   // result side back-pressure
   initial begin
      int n;
      @(negedge reset);
      forever begin
         if (!held_off && readings_seen >= 10) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end else begin
            n = gap_len();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // check results and watch for a hang
   always @(posedge clock) begin
      reading_type got, want;
      bit bad;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= LIMIT_CYCLES) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("simulation failed");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            readings_seen++;
            got.ok = rsp_parse_ok;
            got.kind = rsp_reply_kind;
            got.f[0] = rsp_raw_ppo2;
            got.f[1] = rsp_temperature_dc;
            got.f[2] = rsp_error_word;
            got.f[3] = rsp_optical_phase;
            got.f[4] = rsp_signal_intensity;
            got.f[5] = rsp_ambient_level;
            got.f[6] = rsp_pressure_reading;
            got.f[7] = rsp_humidity_reading;
            got.st = rsp_cell_status;
            if (readings_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected reading at %0t", $realtime);
            end else begin
               want = readings_due.pop_front();
               bad = (got.ok !== want.ok) || (got.kind !== want.kind) ||
                     (got.st !== want.st);
               for (int i = 0; i < 8; i++) if (got.f[i] !== want.f[i]) bad = 1'b1;
               if (want.ok) good_readings++;
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("reading %0d mismatch at %0t", readings_seen, $realtime);
                     $display("  exp ok=%0d kind=%0d st=%0d f=%p",
                              want.ok, want.kind, want.st, want.f);
                     $display("  got ok=%0d kind=%0d st=%0d f=%p",
                              got.ok, got.kind, got.st, got.f);
                  end
               end
            end
         end
      end
   end
endmodule

// ===== files.f =====
rtl/core/ocrp_pkg.sv
rtl/core/ocrp_front.sv
rtl/core/ocrp_queue.sv
rtl/core/ocrp_back.sv
rtl/core/oxygen_cell_reply_parser.sv
tb/sv/testbench.sv
